FILE: hdl/dsp_adpcm_decoder_unit_assert.svh
// Assertion macros shared by the ADPCM decoder checker.
`ifndef DSP_ADPCM_DECODER_UNIT_ASSERT_SVH
`define DSP_ADPCM_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during rst
`define DSPAD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dspad: same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet during rst
`define DSPAD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dspad: next-cycle check failed");

`endif

FILE: hdl/dspad_pkg.sv
// Shared types and constants of the ADPCM decoder.
package dspad_pkg;

  // Coefficient table
  localparam int NUM_PAIRS = 8;
  localparam int PAIR_W    = 32;
  localparam int IDX_W     = 3;
  localparam int ADDR_W    = 5;

  // Accumulator wide enough that the predictor sum never wraps
  localparam int ACC_W   = 34;
  localparam int FRAC_W  = 11;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(34'sh400);
  localparam logic signed [ACC_W-1:0] SAMPLE_MAX = ACC_W'(34'sd32767);
  localparam logic signed [ACC_W-1:0] SAMPLE_MIN = -ACC_W'(34'sd32768);

  // Item modes
  localparam logic [1:0] MODE_HEADER = 2'd0;
  localparam logic [1:0] MODE_DATA   = 2'd1;
  localparam logic [1:0] MODE_LOAD   = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         data_byte;
    logic signed [15:0] load_prev1;
    logic signed [15:0] load_prev2;
  } item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               second_of_pair;
  } result_t;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic en;
    logic load;
  } mac_ctrl_t;

endpackage

FILE: hdl/dspad_ram.sv
// Generic RAM: one write port, two registered read ports.
module dspad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register both reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

FILE: hdl/dspad_mac.sv
// Shared 16x16 signed multiply-accumulate unit of the predictor.
module dspad_mac (
  input  logic                                clk,
  input  dspad_pkg::mac_ctrl_t                ctrl,
  input  logic signed [dspad_pkg::ACC_W-1:0]  base,
  input  logic signed [15:0]                  mul_a,
  input  logic signed [15:0]                  mul_b,
  output logic signed [dspad_pkg::ACC_W-1:0]  acc
);

  logic signed [31:0]                 product;
  logic signed [dspad_pkg::ACC_W-1:0] addend;

  // One product per cycle while enabled, added to a fresh base or to the running sum
  assign product = mul_a * mul_b;
  assign addend  = ctrl.load ? base : acc;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc <= addend + dspad_pkg::ACC_W'(product);
    end
  end

endmodule

FILE: hdl/dsp_adpcm_decoder_unit.sv
// Top level of the 4-bit ADPCM decoder with its register port.
//
// Decodes one byte-wide item at a time. A header or load-history
// transaction is absorbed in the cycle it is accepted and produces no
// result. A data byte holds item_stall high until both of its samples
// have been issued: the sequencer first reads the coefficient pair from
// the table RAM, then per nibble makes two passes through the single
// shared 16x16 multiply-accumulate unit (c1*prev1, then c2*prev2) and
// then rounds, clamps and issues the sample. Each result waits in the
// output register; while it is stalled the sequencer holds before
// issuing the next one, so a stalled result channel also delays the
// next data byte. The coefficient table comes out of reset as all
// zeros.
module dsp_adpcm_decoder_unit (
  input  logic                              clk,
  input  logic                              rst,
  // item channel
  input  logic                              item_valid,
  output logic                              item_stall,
  input  dspad_pkg::item_t                  item,
  // result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output dspad_pkg::result_t                result,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dspad_pkg::ADDR_W-1:0]      paddr,
  input  logic [dspad_pkg::PAIR_W-1:0]      pwdata,
  output logic [dspad_pkg::PAIR_W-1:0]      prdata,
  output logic                              pready
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_MAC1  = 5'b00100,
    S_MAC2  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic signed [15:0]               prev1;
  logic signed [15:0]               prev2;
  logic [3:0]                       exponent;
  logic [dspad_pkg::IDX_W-1:0]      coef_idx;
  logic [3:0]                       nibble;
  logic [3:0]                       low_nibble;
  logic                             second;

  logic                             item_take;
  logic                             cfg_write;
  logic [dspad_pkg::IDX_W-1:0]      cfg_idx;
  logic [dspad_pkg::NUM_PAIRS-1:0]  pair_written;
  logic                             pair_ok_a;
  logic                             pair_ok_b;
  logic [dspad_pkg::PAIR_W-1:0]     ram_data_a;
  logic [dspad_pkg::PAIR_W-1:0]     ram_data_b;
  logic [dspad_pkg::PAIR_W-1:0]     coef_pair;

  dspad_pkg::mac_ctrl_t             mac_ctrl;
  logic signed [dspad_pkg::ACC_W-1:0] base;
  logic signed [dspad_pkg::ACC_W-1:0] nib_ext;
  logic [4:0]                       shamt;
  logic signed [15:0]               mul_a;
  logic signed [15:0]               mul_b;
  logic signed [dspad_pkg::ACC_W-1:0] acc;
  logic signed [dspad_pkg::ACC_W-1:0] y_full;
  logic signed [15:0]               y_clamped;
  logic                             out_free;
  logic                             issue;

  // Handshakes
  assign item_stall = (state != S_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign cfg_idx    = paddr[dspad_pkg::ADDR_W-1:2];

  // Coefficient table
  dspad_ram #(
    .WIDTH (dspad_pkg::PAIR_W),
    .DEPTH (dspad_pkg::NUM_PAIRS)
  ) u_coef_ram (
    .clk       (clk),
    .wr_en     (cfg_write),
    .wr_addr   (cfg_idx),
    .wr_data   (pwdata),
    .rd_addr_a (coef_idx),
    .rd_data_a (ram_data_a),
    .rd_addr_b (cfg_idx),
    .rd_data_b (ram_data_b)
  );

  // Track written entries; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_written <= '0;
      pair_ok_a    <= 1'b0;
      pair_ok_b    <= 1'b0;
    end else begin
      if (cfg_write) begin
        pair_written[cfg_idx] <= 1'b1;
      end
      pair_ok_a <= pair_written[coef_idx];
      pair_ok_b <= pair_written[cfg_idx];
    end
  end

  assign coef_pair = pair_ok_a ? ram_data_a : '0;
  assign prdata    = pair_ok_b ? ram_data_b : '0;

  // Scaled nibble plus rounding half
  assign nib_ext = dspad_pkg::ACC_W'(signed'(nibble));
  assign shamt   = {1'b0, exponent} + 5'(dspad_pkg::FRAC_W);
  assign base    = (nib_ext <<< shamt) + dspad_pkg::ROUND_HALF;

  // Operand select for the shared unit
  assign mul_a = (state == S_MAC1) ? signed'(coef_pair[15:0]) : signed'(coef_pair[31:16]);
  assign mul_b = (state == S_MAC1) ? prev1 : prev2;

  assign mac_ctrl.en   = (state == S_MAC1) || (state == S_MAC2);
  assign mac_ctrl.load = (state == S_MAC1);

  dspad_mac u_mac (
    .clk   (clk),
    .ctrl  (mac_ctrl),
    .base  (base),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .acc   (acc)
  );

  // Drop fraction (floor) and clamp to 16 bits
  assign y_full = acc >>> dspad_pkg::FRAC_W;

  always_comb begin
    if (y_full > dspad_pkg::SAMPLE_MAX) begin
      y_clamped = 16'sh7FFF;
    end else if (y_full < dspad_pkg::SAMPLE_MIN) begin
      y_clamped = -16'sh8000;
    end else begin
      y_clamped = y_full[15:0];
    end
  end

  assign out_free = !result_valid || !result_stall;
  assign issue    = (state == S_DONE) && out_free;

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_take && (item.mode == dspad_pkg::MODE_DATA)) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: state_next = S_MAC1;
      S_MAC1:  state_next = S_MAC2;
      S_MAC2:  state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = second ? S_IDLE : S_MAC1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      prev1    <= '0;
      prev2    <= '0;
      exponent <= '0;
      coef_idx <= '0;
    end else begin
      state <= state_next;
      if (item_take) begin
        case (item.mode)
          dspad_pkg::MODE_HEADER: begin
            exponent <= item.data_byte[3:0];
            coef_idx <= item.data_byte[6:4];
          end
          dspad_pkg::MODE_LOAD: begin
            prev1 <= item.load_prev1;
            prev2 <= item.load_prev2;
          end
          default: ;
        endcase
      end else if (issue) begin
        // Shift the history
        prev2 <= prev1;
        prev1 <= y_clamped;
      end
    end
  end

  // Nibble holding: high nibble first, then low
  always_ff @(posedge clk) begin
    if (item_take) begin
      nibble     <= item.data_byte[7:4];
      low_nibble <= item.data_byte[3:0];
      second     <= 1'b0;
    end else if (issue) begin
      nibble <= low_nibble;
      second <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (issue) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      result.sample         <= y_clamped;
      result.second_of_pair <= second;
    end
  end

endmodule

FILE: hdl/dspad_checker.sv
// Port-level checks of the ADPCM decoder, bound to its top level.
`include "dsp_adpcm_decoder_unit_assert.svh"

module dspad_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         item_valid,
  input logic                         item_stall,
  input dspad_pkg::item_t             item,
  input logic                         result_valid,
  input logic                         result_stall,
  input dspad_pkg::result_t           result
);

  // Stalled result transaction holds
  `DSPAD_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

  // Data byte keeps the block busy
  `DSPAD_ASSERT_NEXT(a_data_busy, item_valid && !item_stall && item.mode == dspad_pkg::MODE_DATA, item_stall)

  // Header and load history are absorbed without making the block busy
  `DSPAD_ASSERT_NEXT(a_ctrl_quick, item_valid && !item_stall && item.mode != dspad_pkg::MODE_DATA, !item_stall)

  // First sample of a pair shows only while the pair is still in work
  `DSPAD_ASSERT_NOW(a_first_busy, result_valid && !result.second_of_pair, item_stall)

endmodule

bind dsp_adpcm_decoder_unit dspad_checker u_dspad_checker (.*);
